@@ src/hcbd_pkg.sv @@
// Package for the chunked body decoder: phase type, result record,
// character constants and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package hcbd_pkg;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // bits per hex digit (radix 16)
    localparam int DIGIT_BITS = 4;

    // bytes dropped after each chunk payload (CR LF)
    localparam logic [1:0] TRAILER_SKIP = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       body_done;
    } result_t;

    typedef struct packed {
        logic                  is_hex;
        logic [DIGIT_BITS-1:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = '0;
        case (c) inside
            [8'h30:8'h39]:
            begin
                h.is_hex = 1'b1;
                h.value  = c[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]:
            begin
                h.is_hex = 1'b1;
                h.value  = 4'(c[3:0] + 4'd9);
            end
            default:
            begin
                h.is_hex = 1'b0;
            end
        endcase
        return h;
    endfunction

endpackage

@@ src/hcbd_in_if.sv @@
// Byte input channel of the chunked body decoder: valid/ready plus raw byte.
// No dependencies.
`timescale 1ns / 1ps

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ src/hcbd_out_if.sv @@
// Result channel of the chunked body decoder: valid/ready plus payload
// byte and flags. No dependencies.
`timescale 1ns / 1ps

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_data;
    logic       body_done;

    modport source (output valid, output out_byte, output has_data, output body_done,
                    input ready);
    modport sink   (input valid, input out_byte, input has_data, input body_done,
                    output ready);
endinterface

@@ src/http_chunked_body_decoder.sv @@
// HTTP chunked transfer-coding body decoder, one byte per cycle.
// Channels: in_ch carries raw body bytes (in_byte); out_ch carries results
// (out_byte, has_data, body_done). A transaction completes when valid and
// ready are both high at a rising clock edge.
// Each byte of a chunk payload yields one result with has_data set; size
// line bytes and the CR LF after each payload yield none. The LF that ends
// a zero-size (or digitless) line yields one result with body_done set,
// after which all bytes are consumed without results.
// A byte accepted into the input register is parsed out of that register
// and its result is loaded into the result register, from which out_ch
// can take it at once.
// Throughput: one byte per cycle while out_ch is not stalled; out_ch.ready
// feeds back combinationally to in_ch.ready.
// When out_ch stalls, the result register holds; bytes that yield no result
// keep flowing, and a result-bearing byte waits in the input register.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a size line.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and the hcbd_* submodules.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    hcbd_in_if.sink    in_ch,
    hcbd_out_if.source out_ch
);

    logic              in_valid;
    logic [7:0]        in_byte_q;
    logic              advance;
    logic              has_result;
    logic              can_load;
    hcbd_pkg::result_t result;

    assign advance = in_valid && (!has_result || can_load);

    hcbd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .valid   (in_valid),
        .byte_q  (in_byte_q)
    );

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .in_byte    (in_byte_q),
        .has_result (has_result),
        .result     (result)
    );

    hcbd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

@@ src/hcbd_in_stage.sv @@
// Input register of the chunked body decoder.
// Depends on hcbd_in_if.
`timescale 1ns / 1ps

module hcbd_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    hcbd_in_if.sink       in_ch,
    input  logic          advance,
    output logic          valid,
    output logic [7:0]    byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_ch.in_byte;
        end
    end

    assign valid  = valid_reg;
    assign byte_q = byte_reg;

endmodule

@@ src/hcbd_parser.sv @@
// Chunk framing state machine: size line parse, payload pass, trailer skip.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_parser #(
    parameter int SIZE_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output logic              has_result,
    output hcbd_pkg::result_t result
);

    hcbd_pkg::phase_t      phase_reg;
    hcbd_pkg::phase_t      phase_next;
    logic [SIZE_BITS-1:0]  acc_reg;
    logic [SIZE_BITS-1:0]  acc_next;
    logic                  closed_reg;
    logic                  closed_next;
    logic                  saw_reg;
    logic                  saw_next;
    logic                  cr_reg;
    logic                  cr_next;
    logic [SIZE_BITS-1:0]  remain_reg;
    logic [SIZE_BITS-1:0]  remain_next;
    logic [1:0]            skip_reg;
    logic [1:0]            skip_next;

    hcbd_pkg::hex_t        hex;
    logic                  line_end;
    logic                  last_payload;
    logic                  skip_last;
    logic                  size_empty;

    assign hex          = hcbd_pkg::hex_decode(in_byte);
    assign line_end     = (in_byte == hcbd_pkg::CHAR_LF) && cr_reg;
    assign last_payload = (remain_reg == SIZE_BITS'(1));
    assign skip_last    = (skip_reg <= 2'd1);
    assign size_empty   = !saw_reg || (acc_reg == '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                if (line_end)
                begin
                    phase_next = size_empty ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                if (last_payload)
                begin
                    phase_next = hcbd_pkg::PH_SKIP;
                end
            end
            hcbd_pkg::PH_SKIP:
            begin
                if (skip_last)
                begin
                    phase_next = hcbd_pkg::PH_SIZE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        acc_next         = acc_reg;
        closed_next      = closed_reg;
        saw_next         = saw_reg;
        cr_next          = cr_reg;
        remain_next      = remain_reg;
        skip_next        = skip_reg;
        has_result       = 1'b0;
        result.out_byte  = '0;
        result.has_data  = 1'b0;
        result.body_done = 1'b0;
        case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                if (line_end)
                begin
                    if (size_empty)
                    begin
                        has_result       = 1'b1;
                        result.body_done = 1'b1;
                    end
                    else
                    begin
                        remain_next = acc_reg;
                        acc_next    = '0;
                        closed_next = 1'b0;
                        saw_next    = 1'b0;
                        cr_next     = 1'b0;
                    end
                end
                else
                begin
                    cr_next = (in_byte == hcbd_pkg::CHAR_CR);
                    if (!closed_reg)
                    begin
                        if (hex.is_hex)
                        begin
                            // saturate once any of the top digit bits is set
                            if (|acc_reg[SIZE_BITS-1 -: hcbd_pkg::DIGIT_BITS])
                            begin
                                acc_next = '1;
                            end
                            else
                            begin
                                acc_next = {acc_reg[SIZE_BITS-1-hcbd_pkg::DIGIT_BITS:0],
                                            hex.value};
                            end
                            saw_next = 1'b1;
                        end
                        else if (!saw_reg && ((in_byte == hcbd_pkg::CHAR_SP) ||
                                              (in_byte == hcbd_pkg::CHAR_TAB)))
                        begin
                            closed_next = 1'b0;
                        end
                        else
                        begin
                            closed_next = 1'b1;
                        end
                    end
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                has_result      = 1'b1;
                result.out_byte = in_byte;
                result.has_data = 1'b1;
                remain_next     = remain_reg - SIZE_BITS'(1);
                if (last_payload)
                begin
                    skip_next = hcbd_pkg::TRAILER_SKIP;
                end
            end
            hcbd_pkg::PH_SKIP:
            begin
                if (skip_reg != 2'd0)
                begin
                    skip_next = skip_reg - 2'd1;
                end
                if (skip_last)
                begin
                    acc_next    = '0;
                    closed_next = 1'b0;
                    saw_next    = 1'b0;
                    cr_next     = 1'b0;
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hcbd_pkg::PH_SIZE;
            acc_reg    <= '0;
            closed_reg <= 1'b0;
            saw_reg    <= 1'b0;
            cr_reg     <= 1'b0;
            remain_reg <= '0;
            skip_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            closed_reg <= closed_next;
            saw_reg    <= saw_next;
            cr_reg     <= cr_next;
            remain_reg <= remain_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

@@ src/hcbd_out_stage.sv @@
// Result register of the chunked body decoder.
// Depends on hcbd_pkg and hcbd_out_if.
`timescale 1ns / 1ps

module hcbd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hcbd_pkg::result_t result,
    output logic              can_load,
    hcbd_out_if.source        out_ch
);

    logic              valid_reg;
    logic              valid_next;
    hcbd_pkg::result_t data_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_byte  = data_reg.out_byte;
    assign out_ch.has_data  = data_reg.has_data;
    assign out_ch.body_done = data_reg.body_done;

endmodule
